// ----- design/shutter_motor_controller_macros.svh -----
// ----------------------------------------------------------------------------
// Shutter motor controller assertion macros
// Concurrent check shorthands, clocked on aclk and masked during reset.
// ----------------------------------------------------------------------------
`ifndef SHUTTER_MOTOR_CONTROLLER_MACROS_SVH
`define SHUTTER_MOTOR_CONTROLLER_MACROS_SVH

// same-cycle implication
`define SMC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("shutter motor controller: same-cycle check failed");

// next-cycle implication
`define SMC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("shutter motor controller: next-cycle check failed");

`endif

// ----- design/smc_pkg.sv -----
// ----------------------------------------------------------------------------
// smc_pkg
// Shared widths, register defaults, codes and control structs.
// ----------------------------------------------------------------------------
package smc_pkg;

    localparam int unsigned CfgW   = 16;
    localparam int unsigned ErrW   = 5;
    localparam int unsigned StateW = 2;
    localparam int unsigned StatW  = 3;

    localparam logic [CfgW-1:0] OpenTimeoutRst  = 16'd3000;
    localparam logic [CfgW-1:0] CloseTimeoutRst = 16'd3000;
    localparam logic [CfgW-1:0] MotionBlinkRst  = 16'd50;
    localparam logic [CfgW-1:0] ErrorBlinkRst   = 16'd35;

    // error flag bits
    localparam logic [ErrW-1:0] ErrCloseTimeout = 5'h01;
    localparam logic [ErrW-1:0] ErrOpenTimeout  = 5'h02;
    localparam logic [ErrW-1:0] ErrBothSensors  = 5'h10;
    localparam logic [ErrW-1:0] ErrMask = ErrCloseTimeout | ErrOpenTimeout | ErrBothSensors;

    // lamp status codes
    localparam logic [StatW-1:0] StatNone      = 3'd0;
    localparam logic [StatW-1:0] StatSteadyOn  = 3'd1;
    localparam logic [StatW-1:0] StatSteadyOff = 3'd2;
    localparam logic [StatW-1:0] StatBlinkOn   = 3'd3;
    localparam logic [StatW-1:0] StatBlinkOff  = 3'd4;

    typedef enum logic [1:0] {
        CFG_OPEN_TIMEOUT  = 2'd0,
        CFG_CLOSE_TIMEOUT = 2'd1,
        CFG_MOTION_BLINK  = 2'd2,
        CFG_ERROR_BLINK   = 2'd3
    } cfg_idx_t;

    // per-lamp view of the updated shutter state
    typedef struct packed {
        logic clear;   // any button edge this item
        logic steady;  // idle, no error
        logic slow;    // own direction moving, no error
        logic fast;    // error set
        logic sensor;  // own end sensor level
    } lamp_ctl_t;

    // updated controller outputs for the result register
    typedef struct packed {
        logic              motor_open;
        logic              motor_close;
        logic [StateW-1:0] state;
        logic [ErrW-1:0]   err;
    } ctrl_out_t;

endpackage

// ----- design/smc_ctrl.sv -----
// ----------------------------------------------------------------------------
// smc_ctrl
// Shutter mode machine: button edges, end sensors, timeouts and motor levels.
// ----------------------------------------------------------------------------
`include "shutter_motor_controller_macros.svh"

module smc_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  logic                          open_button,
    input  logic                          close_button,
    input  logic                          open_sensor,
    input  logic                          close_sensor,
    input  logic [smc_pkg::CfgW-1:0]      open_ticks,
    input  logic [smc_pkg::CfgW-1:0]      close_ticks,
    output smc_pkg::ctrl_out_t            ctrl_next,
    output smc_pkg::lamp_ctl_t            open_lamp,
    output smc_pkg::lamp_ctl_t            close_lamp
);

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_CLOSING = 2'd2,
        MODE_ERROR   = 2'd3
    } mode_t;

    mode_t                      mode_reg, mode_next;
    logic [smc_pkg::ErrW-1:0]   err_reg, err_next;
    logic [smc_pkg::CfgW-1:0]   otc_reg, otc_next, otc_dec;
    logic [smc_pkg::CfgW-1:0]   ctc_reg, ctc_next, ctc_dec;
    logic                       prev_open_reg, prev_close_reg;
    logic                       mo_reg, mo_next;
    logic                       mc_reg, mc_next;
    logic                       ev_open, ev_close;

    always_comb begin
        ev_open  = !prev_open_reg && open_button;
        ev_close = !prev_close_reg && close_button;
        otc_dec  = (otc_reg != '0) ? otc_reg - 1'b1 : otc_reg;
        ctc_dec  = (ctc_reg != '0) ? ctc_reg - 1'b1 : ctc_reg;

        mode_next = mode_reg;
        err_next  = err_reg;
        otc_next  = otc_dec;
        ctc_next  = ctc_dec;
        mo_next   = mo_reg;
        mc_next   = mc_reg;

        unique case (mode_reg)
            MODE_IDLE: begin
                if (ev_open) begin
                    err_next  = '0;
                    mo_next   = 1'b1;
                    otc_next  = open_ticks;
                    mode_next = MODE_OPENING;
                end
                // close wins the mode, but the open motor stays on
                if (ev_close) begin
                    err_next  = '0;
                    mc_next   = 1'b1;
                    ctc_next  = close_ticks;
                    mode_next = MODE_CLOSING;
                end
                if (open_sensor && close_sensor) begin
                    err_next = err_next | smc_pkg::ErrBothSensors;
                end
            end
            MODE_OPENING: begin
                if (open_sensor || ev_close) begin
                    otc_next  = '0;
                    mo_next   = 1'b0;
                    mode_next = MODE_IDLE;
                end else if (otc_dec == '0) begin
                    err_next  = err_reg | smc_pkg::ErrOpenTimeout;
                    mode_next = MODE_ERROR;
                end
            end
            MODE_CLOSING: begin
                if (close_sensor || ev_open) begin
                    ctc_next  = '0;
                    mc_next   = 1'b0;
                    mode_next = MODE_IDLE;
                end else if (ctc_dec == '0) begin
                    err_next  = err_reg | smc_pkg::ErrCloseTimeout;
                    mode_next = MODE_ERROR;
                end
            end
            MODE_ERROR: begin
                mo_next   = 1'b0;
                mc_next   = 1'b0;
                mode_next = MODE_IDLE;
            end
            default: begin
                mode_next = MODE_IDLE;
            end
        endcase

        ctrl_next.motor_open  = mo_next;
        ctrl_next.motor_close = mc_next;
        ctrl_next.state       = mode_next;
        ctrl_next.err         = err_next;

        // lamps see the mode and flags after this item's update
        open_lamp.clear   = ev_open || ev_close;
        open_lamp.steady  = (err_next == '0) && (mode_next == MODE_IDLE);
        open_lamp.slow    = (err_next == '0) && (mode_next == MODE_OPENING);
        open_lamp.fast    = (err_next != '0);
        open_lamp.sensor  = open_sensor;

        close_lamp.clear  = ev_open || ev_close;
        close_lamp.steady = (err_next == '0) && (mode_next == MODE_IDLE);
        close_lamp.slow   = (err_next == '0) && (mode_next == MODE_CLOSING);
        close_lamp.fast   = (err_next != '0);
        close_lamp.sensor = close_sensor;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_IDLE;
            err_reg        <= '0;
            otc_reg        <= '0;
            ctc_reg        <= '0;
            prev_open_reg  <= 1'b1;
            prev_close_reg <= 1'b1;
            mo_reg         <= 1'b0;
            mc_reg         <= 1'b0;
        end else if (step) begin
            mode_reg       <= mode_next;
            err_reg        <= err_next;
            otc_reg        <= otc_next;
            ctc_reg        <= ctc_next;
            prev_open_reg  <= open_button;
            prev_close_reg <= close_button;
            mo_reg         <= mo_next;
            mc_reg         <= mc_next;
        end
    end

    // error state lasts one item, then both motors stop
    `SMC_ASSERT_NXT(a_error_one_item, step && (mode_reg == MODE_ERROR),
                    (mode_reg == MODE_IDLE) && !mo_reg && !mc_reg)
    // an error mode always carries a timeout flag
    `SMC_ASSERT_IMP(a_error_has_flag, mode_reg == MODE_ERROR,
                    (err_reg & (smc_pkg::ErrOpenTimeout | smc_pkg::ErrCloseTimeout)) != '0)

endmodule

// ----- design/smc_lamp.sv -----
// ----------------------------------------------------------------------------
// smc_lamp
// One indicator lamp: steady level when idle with no error, blink machine otherwise.
// ----------------------------------------------------------------------------
module smc_lamp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,
    input  smc_pkg::lamp_ctl_t            ctl,
    input  logic [smc_pkg::CfgW-1:0]      motion_ticks,
    input  logic [smc_pkg::CfgW-1:0]      error_ticks,
    output logic                          light_next,
    output logic [smc_pkg::StatW-1:0]     status
);

    typedef enum logic [2:0] {
        PHASE_REST      = 3'd0,
        PHASE_LIGHT     = 3'd1,
        PHASE_DARK      = 3'd2,
        PHASE_LIT_HOLD  = 3'd3,
        PHASE_DARK_HOLD = 3'd4
    } blink_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_SLOW = 2'd1,
        CMD_FAST = 2'd2
    } cmd_t;

    blink_t                     blink_reg, blink_next;
    cmd_t                       cmd_reg, cmd_next;
    logic [smc_pkg::CfgW-1:0]   cnt_reg, cnt_next;
    logic [smc_pkg::CfgW-1:0]   per_reg, per_next;
    logic                       light_reg;

    always_comb begin
        blink_next = blink_reg;
        cmd_next   = cmd_reg;
        cnt_next   = (cnt_reg != '0) ? cnt_reg - 1'b1 : cnt_reg;
        per_next   = per_reg;
        light_next = light_reg;
        status     = smc_pkg::StatNone;

        if (ctl.clear) begin
            cnt_next   = '0;
            cmd_next   = CMD_NONE;
            blink_next = PHASE_REST;
            light_next = 1'b0;
        end

        if (ctl.steady) begin
            light_next = ctl.sensor;
            cmd_next   = CMD_NONE;
            status     = ctl.sensor ? smc_pkg::StatSteadyOn : smc_pkg::StatSteadyOff;
        end else if (ctl.slow) begin
            cmd_next = CMD_SLOW;
        end else if (ctl.fast) begin
            cmd_next = CMD_FAST;
        end

        unique case (blink_next)
            PHASE_REST: begin
                if (cmd_next != CMD_NONE) begin
                    per_next   = (cmd_next == CMD_SLOW) ? motion_ticks : error_ticks;
                    cnt_next   = per_next;
                    blink_next = PHASE_LIGHT;
                end
            end
            PHASE_LIGHT: begin
                light_next = 1'b1;
                blink_next = PHASE_LIT_HOLD;
            end
            PHASE_LIT_HOLD: begin
                status = smc_pkg::StatBlinkOn;
                if (cnt_next == '0) begin
                    cnt_next   = per_next;
                    blink_next = PHASE_DARK;
                end
            end
            PHASE_DARK: begin
                light_next = 1'b0;
                blink_next = PHASE_DARK_HOLD;
            end
            PHASE_DARK_HOLD: begin
                status = smc_pkg::StatBlinkOff;
                if (cnt_next == '0) begin
                    cnt_next   = per_next;
                    blink_next = PHASE_REST;
                end
            end
            default: begin
                blink_next = PHASE_REST;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blink_reg <= PHASE_REST;
            cmd_reg   <= CMD_NONE;
            cnt_reg   <= '0;
            per_reg   <= '0;
            light_reg <= 1'b0;
        end else if (step) begin
            blink_reg <= blink_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            per_reg   <= per_next;
            light_reg <= light_next;
        end
    end

endmodule

// ----- design/shutter_motor_controller.sv -----
// ----------------------------------------------------------------------------
// shutter_motor_controller
// Roller shutter control: buttons and end sensors in, motors, lamps, status out.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per control tick, carrying the open/close button
//   levels and the open/close end sensor levels (valid/ready).
//   m_ channel: exactly one result item per input item, in order: motor
//   drives, lamp levels, shutter state, error flags and lamp status codes.
//   cfg_ port: plain write (cfg_wr_en, cfg_index, cfg_wdata), no read-back;
//   write only while no item is in flight.
//   Path: each item passes the input register, then the tick update goes
//   straight into the result register; a full, stalled result register
//   holds the item in the input register.
//   Throughput is one item per cycle while m_ready is high; the whole tick
//   update is a single pass through the mode machine and the two lamp machines.
//   Reset (aresetn low, synchronous) idles the shutter, clears errors,
//   counters and both pipeline stages, loads the default timeouts and blink
//   periods, and treats both buttons as already held.
//   When m_ready is low the result holds; the input register still takes
//   one more item, after which s_ready drops until the result is taken.
// ----------------------------------------------------------------------------
`include "shutter_motor_controller_macros.svh"

module shutter_motor_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [smc_pkg::CfgW-1:0]          cfg_wdata,
    // input items
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_open_button,
    input  logic                              s_close_button,
    input  logic                              s_open_sensor,
    input  logic                              s_close_sensor,
    // result items
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_motor_open,
    output logic                              m_motor_close,
    output logic                              m_light_open,
    output logic                              m_light_close,
    output logic [smc_pkg::StateW-1:0]        m_shutter_state,
    output logic [smc_pkg::ErrW-1:0]          m_error_flags,
    output logic [smc_pkg::StatW-1:0]         m_close_light_status,
    output logic [smc_pkg::StatW-1:0]         m_open_light_status
);

    // configuration registers
    logic [smc_pkg::CfgW-1:0] open_to_reg, close_to_reg, motion_blink_reg, error_blink_reg;

    // input stage
    logic in_valid_reg;
    logic ob_reg, cb_reg, os_reg, cs_reg;

    // result stage
    logic                         m_valid_reg;
    logic                         m_mo_reg, m_mc_reg, m_lo_reg, m_lc_reg;
    logic [smc_pkg::StateW-1:0]   m_state_reg;
    logic [smc_pkg::ErrW-1:0]     m_err_reg;
    logic [smc_pkg::StatW-1:0]    m_cstat_reg, m_ostat_reg;

    logic                         advance;
    smc_pkg::ctrl_out_t           ctrl_next;
    smc_pkg::lamp_ctl_t           open_lamp, close_lamp;
    logic                         light_open_next, light_close_next;
    logic [smc_pkg::StatW-1:0]    open_stat, close_stat;

    // an item leaves the input stage when the result slot is free or freeing
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_to_reg      <= smc_pkg::OpenTimeoutRst;
            close_to_reg     <= smc_pkg::CloseTimeoutRst;
            motion_blink_reg <= smc_pkg::MotionBlinkRst;
            error_blink_reg  <= smc_pkg::ErrorBlinkRst;
        end else if (cfg_wr_en) begin
            unique case (smc_pkg::cfg_idx_t'(cfg_index))
                smc_pkg::CFG_OPEN_TIMEOUT:  open_to_reg      <= cfg_wdata;
                smc_pkg::CFG_CLOSE_TIMEOUT: close_to_reg     <= cfg_wdata;
                smc_pkg::CFG_MOTION_BLINK:  motion_blink_reg <= cfg_wdata;
                smc_pkg::CFG_ERROR_BLINK:   error_blink_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            ob_reg <= s_open_button;
            cb_reg <= s_close_button;
            os_reg <= s_open_sensor;
            cs_reg <= s_close_sensor;
        end
    end

    smc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .open_button  (ob_reg),
        .close_button (cb_reg),
        .open_sensor  (os_reg),
        .close_sensor (cs_reg),
        .open_ticks   (open_to_reg),
        .close_ticks  (close_to_reg),
        .ctrl_next    (ctrl_next),
        .open_lamp    (open_lamp),
        .close_lamp   (close_lamp)
    );

    // close and open lamps update together on each step; they share no state
    smc_lamp u_close_lamp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .ctl          (close_lamp),
        .motion_ticks (motion_blink_reg),
        .error_ticks  (error_blink_reg),
        .light_next   (light_close_next),
        .status       (close_stat)
    );

    smc_lamp u_open_lamp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (advance),
        .ctl          (open_lamp),
        .motion_ticks (motion_blink_reg),
        .error_ticks  (error_blink_reg),
        .light_next   (light_open_next),
        .status       (open_stat)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_mo_reg    <= ctrl_next.motor_open;
            m_mc_reg    <= ctrl_next.motor_close;
            m_lo_reg    <= light_open_next;
            m_lc_reg    <= light_close_next;
            m_state_reg <= ctrl_next.state;
            m_err_reg   <= ctrl_next.err;
            m_cstat_reg <= close_stat;
            m_ostat_reg <= open_stat;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_motor_open         = m_mo_reg;
    assign m_motor_close        = m_mc_reg;
    assign m_light_open         = m_lo_reg;
    assign m_light_close        = m_lc_reg;
    assign m_shutter_state      = m_state_reg;
    assign m_error_flags        = m_err_reg;
    assign m_close_light_status = m_cstat_reg;
    assign m_open_light_status  = m_ostat_reg;

    // input stage only blocks behind a stalled, full result stage
    `SMC_ASSERT_IMP(a_stall_cause, in_valid_reg && !s_ready, m_valid_reg && !m_ready)
    // an item leaving the input stage always lands in the result stage
    `SMC_ASSERT_NXT(a_advance_fills, advance, m_valid_reg)
    // only the defined flag bits can ever be set
    `SMC_ASSERT_IMP(a_err_bits, m_valid_reg, (m_error_flags & ~smc_pkg::ErrMask) == '0)

endmodule

// ----- sim/smc_tick_checker.sv -----
// ----------------------------------------------------------------------------
// smc_tick_checker
// Watches the tick and result channels of the shutter motor controller, keeps
// its own model of the controller, and compares every result item field by
// field with the prediction made when the matching tick was taken.
// ----------------------------------------------------------------------------
module smc_tick_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_index,
    input  logic [smc_pkg::CfgW-1:0]      cfg_wdata,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_open_button,
    input  logic                          s_close_button,
    input  logic                          s_open_sensor,
    input  logic                          s_close_sensor,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_motor_open,
    input  logic                          m_motor_close,
    input  logic                          m_light_open,
    input  logic                          m_light_close,
    input  logic [smc_pkg::StateW-1:0]    m_shutter_state,
    input  logic [smc_pkg::ErrW-1:0]      m_error_flags,
    input  logic [smc_pkg::StatW-1:0]     m_close_light_status,
    input  logic [smc_pkg::StatW-1:0]     m_open_light_status,
    output int unsigned                   mismatches,
    output int unsigned                   outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_OPENING = 2'd1,
        MODE_CLOSING = 2'd2,
        MODE_ERROR   = 2'd3
    } shutter_mode_t;

    typedef enum logic [2:0] {
        PHASE_REST      = 3'd0,
        PHASE_LIGHT     = 3'd1,
        PHASE_DARK      = 3'd2,
        PHASE_LIT_HOLD  = 3'd3,
        PHASE_DARK_HOLD = 3'd4
    } blink_mode_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_SLOW = 2'd1,
        CMD_FAST = 2'd2
    } blink_cmd_t;

    localparam int LAMP_CLOSE = 0;
    localparam int LAMP_OPEN  = 1;

    typedef struct packed {
        logic                       motor_open;
        logic                       motor_close;
        logic                       light_open;
        logic                       light_close;
        logic [smc_pkg::StateW-1:0] state;
        logic [smc_pkg::ErrW-1:0]   err;
        logic [smc_pkg::StatW-1:0]  close_stat;
        logic [smc_pkg::StatW-1:0]  open_stat;
    } tick_result_t;

    // register copies
    logic [smc_pkg::CfgW-1:0] open_timeout, close_timeout, motion_blink, error_blink;

    // controller copy
    shutter_mode_t            mode;
    logic [smc_pkg::ErrW-1:0] err_bits;
    logic [15:0]              open_to_cnt, close_to_cnt;
    logic                     prev_open_btn, prev_close_btn;
    logic                     motor_open, motor_close;
    blink_mode_t              blink_mode [2];
    blink_cmd_t               blink_cmd  [2];
    logic [15:0]              blink_cnt  [2];
    logic [15:0]              blink_per  [2];
    logic                     lamp_level [2];

    tick_result_t    due_results [$];
    int unsigned     fails = 0;

    function automatic logic [15:0] count_down(input logic [15:0] c);
        return (c != 16'd0) ? c - 16'd1 : c;
    endfunction

    function automatic void restore_defaults();
        open_timeout   = smc_pkg::OpenTimeoutRst;
        close_timeout  = smc_pkg::CloseTimeoutRst;
        motion_blink   = smc_pkg::MotionBlinkRst;
        error_blink    = smc_pkg::ErrorBlinkRst;
        mode           = MODE_IDLE;
        err_bits       = '0;
        open_to_cnt    = '0;
        close_to_cnt   = '0;
        prev_open_btn  = 1'b1;
        prev_close_btn = 1'b1;
        motor_open     = 1'b0;
        motor_close    = 1'b0;
        for (int i = 0; i < 2; i++) begin
            blink_mode[i] = PHASE_REST;
            blink_cmd[i]  = CMD_NONE;
            blink_cnt[i]  = '0;
            blink_per[i]  = '0;
            lamp_level[i] = 1'b0;
        end
    endfunction

    // one lamp's command update and blink machine step; returns its status code
    function automatic logic [smc_pkg::StatW-1:0] lamp_advance(input int ln,
                                                               input logic sensor,
                                                               input shutter_mode_t moving);
        logic [smc_pkg::StatW-1:0] stat;
        stat = smc_pkg::StatNone;
        if (err_bits == '0 && mode == MODE_IDLE) begin
            lamp_level[ln] = sensor;
            blink_cmd[ln]  = CMD_NONE;
            stat           = sensor ? smc_pkg::StatSteadyOn : smc_pkg::StatSteadyOff;
        end else if (err_bits == '0 && mode == moving) begin
            blink_cmd[ln] = CMD_SLOW;
        end else if (err_bits != '0) begin
            blink_cmd[ln] = CMD_FAST;
        end
        // otherwise the other direction moves: last command kept

        case (blink_mode[ln])
            PHASE_REST: begin
                if (blink_cmd[ln] != CMD_NONE) begin
                    blink_per[ln]  = (blink_cmd[ln] == CMD_SLOW) ? motion_blink : error_blink;
                    blink_cnt[ln]  = blink_per[ln];
                    blink_mode[ln] = PHASE_LIGHT;
                end
            end
            PHASE_LIGHT: begin
                lamp_level[ln] = 1'b1;
                blink_mode[ln] = PHASE_LIT_HOLD;
            end
            PHASE_LIT_HOLD: begin
                stat = smc_pkg::StatBlinkOn;
                if (blink_cnt[ln] == 16'd0) begin
                    blink_cnt[ln]  = blink_per[ln];
                    blink_mode[ln] = PHASE_DARK;
                end
            end
            PHASE_DARK: begin
                lamp_level[ln] = 1'b0;
                blink_mode[ln] = PHASE_DARK_HOLD;
            end
            PHASE_DARK_HOLD: begin
                stat = smc_pkg::StatBlinkOff;
                if (blink_cnt[ln] == 16'd0) begin
                    blink_cnt[ln]  = blink_per[ln];
                    blink_mode[ln] = PHASE_REST;
                end
            end
            default: begin
                blink_mode[ln] = PHASE_REST;
            end
        endcase
        return stat;
    endfunction

    task automatic predict_tick(input logic ob, input logic cb, input logic os, input logic cs);
        logic         ev_open, ev_close;
        tick_result_t res;
        ev_open        = !prev_open_btn && ob;
        ev_close       = !prev_close_btn && cb;
        prev_open_btn  = ob;
        prev_close_btn = cb;
        close_to_cnt   = count_down(close_to_cnt);
        open_to_cnt    = count_down(open_to_cnt);

        case (mode)
            MODE_IDLE: begin
                if (ev_open) begin
                    err_bits    = '0;
                    motor_open  = 1'b1;
                    open_to_cnt = open_timeout;
                    mode        = MODE_OPENING;
                end
                // both edges at once: closing wins, motor_open left on
                if (ev_close) begin
                    err_bits     = '0;
                    motor_close  = 1'b1;
                    close_to_cnt = close_timeout;
                    mode         = MODE_CLOSING;
                end
                if (os && cs) begin
                    err_bits = err_bits | smc_pkg::ErrBothSensors;
                end
            end
            MODE_OPENING: begin
                if (os || ev_close) begin
                    open_to_cnt = '0;
                    motor_open  = 1'b0;
                    mode        = MODE_IDLE;
                end else if (open_to_cnt == 16'd0) begin
                    err_bits = err_bits | smc_pkg::ErrOpenTimeout;
                    mode     = MODE_ERROR;
                end
            end
            MODE_CLOSING: begin
                if (cs || ev_open) begin
                    close_to_cnt = '0;
                    motor_close  = 1'b0;
                    mode         = MODE_IDLE;
                end else if (close_to_cnt == 16'd0) begin
                    err_bits = err_bits | smc_pkg::ErrCloseTimeout;
                    mode     = MODE_ERROR;
                end
            end
            default: begin
                motor_open  = 1'b0;
                motor_close = 1'b0;
                mode        = MODE_IDLE;
            end
        endcase

        for (int i = 0; i < 2; i++) begin
            blink_cnt[i] = count_down(blink_cnt[i]);
        end
        if (ev_open || ev_close) begin
            for (int i = 0; i < 2; i++) begin
                blink_cnt[i]  = '0;
                blink_cmd[i]  = CMD_NONE;
                blink_mode[i] = PHASE_REST;
                lamp_level[i] = 1'b0;
            end
        end

        res.close_stat  = lamp_advance(LAMP_CLOSE, cs, MODE_CLOSING);
        res.open_stat   = lamp_advance(LAMP_OPEN, os, MODE_OPENING);
        res.motor_open  = motor_open;
        res.motor_close = motor_close;
        res.light_open  = lamp_level[LAMP_OPEN];
        res.light_close = lamp_level[LAMP_CLOSE];
        res.state       = mode;
        res.err         = err_bits;
        due_results.push_back(res);
    endtask

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        tick_result_t want;
        if (!aresetn) begin
            restore_defaults();
            due_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (smc_pkg::cfg_idx_t'(cfg_index))
                    smc_pkg::CFG_OPEN_TIMEOUT:  open_timeout  = cfg_wdata;
                    smc_pkg::CFG_CLOSE_TIMEOUT: close_timeout = cfg_wdata;
                    smc_pkg::CFG_MOTION_BLINK:  motion_blink  = cfg_wdata;
                    smc_pkg::CFG_ERROR_BLINK:   error_blink   = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    fails++;
                    $display("%0t: result item with none expected", $time);
                end else begin
                    want = due_results.pop_front();
                    check_field("motor_open", 8'(want.motor_open), 8'(m_motor_open));
                    check_field("motor_close", 8'(want.motor_close), 8'(m_motor_close));
                    check_field("light_open", 8'(want.light_open), 8'(m_light_open));
                    check_field("light_close", 8'(want.light_close), 8'(m_light_close));
                    check_field("shutter_state", 8'(want.state), 8'(m_shutter_state));
                    check_field("error_flags", 8'(want.err), 8'(m_error_flags));
                    check_field("close_light_status", 8'(want.close_stat),
                                8'(m_close_light_status));
                    check_field("open_light_status", 8'(want.open_stat),
                                8'(m_open_light_status));
                end
            end
            if (s_valid && s_ready) begin
                predict_tick(s_open_button, s_close_button, s_open_sensor, s_close_sensor);
            end
        end
        outstanding <= due_results.size();
        mismatches  <= fails;
    end

endmodule

// ----- sim/shutter_motor_controller_tb.sv -----
// ----------------------------------------------------------------------------
// shutter_motor_controller_tb
// Drives button and sensor ticks into the shutter controller through several
// register settings, with random gaps and back-pressure, and reports the
// verdict from the checker that sits beside the block.
// ----------------------------------------------------------------------------
module shutter_motor_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no item moving on either channel before the run is abandoned
    localparam int QUIET_LIMIT = 2000;

    // directed ticks, {open_button, close_button, open_sensor, close_sensor}
    localparam logic [3:0] DIRECTED_TICKS [0:25] = '{
        4'b1100,    // buttons held through reset: no edge
        4'b0001,    // released, shutter closed: steady lamps
        4'b1001,    // open pressed
        4'b1000,
        4'b0000,
        4'b0010,    // open sensor reached
        4'b0110,    // close pressed
        4'b0100,
        4'b0100,
        4'b0100,
        4'b0100,    // close sensor never came: timeout, error tick follows
        4'b0000,
        4'b1100,    // both buttons rise while idle: closing, both motors on
        4'b0000,
        4'b0001,    // closed, motor_open stays on
        4'b0011,    // both sensors while idle
        4'b1011,    // open press clears the flag, then sets it again
        4'b0000,
        4'b0100,    // close press stops the opening
        4'b0000,
        4'b1000,    // open with no sensor: open timeout
        4'b1000,
        4'b1000,
        4'b1000,
        4'b0000,
        4'b0010
    };

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [1:0]                    cfg_index;
    logic [smc_pkg::CfgW-1:0]      cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_open_button;
    logic                          s_close_button;
    logic                          s_open_sensor;
    logic                          s_close_sensor;
    logic                          m_valid;
    logic                          m_ready;
    logic                          m_motor_open;
    logic                          m_motor_close;
    logic                          m_light_open;
    logic                          m_light_close;
    logic [smc_pkg::StateW-1:0]    m_shutter_state;
    logic [smc_pkg::ErrW-1:0]      m_error_flags;
    logic [smc_pkg::StatW-1:0]     m_close_light_status;
    logic [smc_pkg::StatW-1:0]     m_open_light_status;

    int unsigned         fail_count;
    int unsigned         in_flight;
    int                  items_sent  = 0;
    int                  quiet_cycles = 0;
    logic                tx_calm     = 1'b0;
    // sensor levels the shutter is resting on between moves
    logic                open_lvl    = 1'b0;
    logic                close_lvl   = 1'b1;

    shutter_motor_controller u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_open_button        (s_open_button),
        .s_close_button       (s_close_button),
        .s_open_sensor        (s_open_sensor),
        .s_close_sensor       (s_close_sensor),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_motor_open         (m_motor_open),
        .m_motor_close        (m_motor_close),
        .m_light_open         (m_light_open),
        .m_light_close        (m_light_close),
        .m_shutter_state      (m_shutter_state),
        .m_error_flags        (m_error_flags),
        .m_close_light_status (m_close_light_status),
        .m_open_light_status  (m_open_light_status)
    );

    smc_tick_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wr_en            (cfg_wr_en),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_open_button        (s_open_button),
        .s_close_button       (s_close_button),
        .s_open_sensor        (s_open_sensor),
        .s_close_sensor       (s_close_sensor),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_motor_open         (m_motor_open),
        .m_motor_close        (m_motor_close),
        .m_light_open         (m_light_open),
        .m_light_close        (m_light_close),
        .m_shutter_state      (m_shutter_state),
        .m_error_flags        (m_error_flags),
        .m_close_light_status (m_close_light_status),
        .m_open_light_status  (m_open_light_status),
        .mismatches           (fail_count),
        .outstanding          (in_flight)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Watchdog: a stuck handshake ends the run rather than hanging it.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side back-pressure: mostly short stalls, now and then a long one,
    // and calm windows in which ready simply stays high.
    initial begin : result_sink
        int   stall;
        int   span;
        logic calm;
        stall = 0;
        span  = 0;
        calm  = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (span == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                span = $urandom_range(50, 300);
            end
            span--;
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else if (!calm && $urandom_range(0, 99) < 20) begin
                stall = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sender gap before an item: none in calm episodes, otherwise mostly
    // none, sometimes short, with the odd long one.
    function automatic int tx_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 70) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Present one tick and hold it until it is taken. Returns at the edge that
    // takes it, with valid still high for a possible back-to-back item.
    task automatic send_item(input logic ob, input logic cb, input logic os, input logic cs);
        int gap;
        gap = tx_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_open_button  <= ob;
        s_close_button <= cb;
        s_open_sensor  <= os;
        s_close_sensor <= cs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Hold off the sender until every result has been taken, so the block
    // is quiet before any register write.
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [smc_pkg::CfgW-1:0] open_to,
                              input logic [smc_pkg::CfgW-1:0] close_to,
                              input logic [smc_pkg::CfgW-1:0] motion_bl,
                              input logic [smc_pkg::CfgW-1:0] error_bl);
        cfg_wr_en <= 1'b1;
        cfg_index <= smc_pkg::CFG_OPEN_TIMEOUT;
        cfg_wdata <= open_to;
        @(posedge aclk);
        cfg_index <= smc_pkg::CFG_CLOSE_TIMEOUT;
        cfg_wdata <= close_to;
        @(posedge aclk);
        cfg_index <= smc_pkg::CFG_MOTION_BLINK;
        cfg_wdata <= motion_bl;
        @(posedge aclk);
        cfg_index <= smc_pkg::CFG_ERROR_BLINK;
        cfg_wdata <= error_bl;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // A move in one direction: sensors clear while travelling, the button
    // held or let go at random, then the end sensor arrives. With short
    // timeouts the sensor often comes too late and the move times out.
    task automatic travel(input logic to_open, input int cap);
        logic held;
        open_lvl  = 1'b0;
        close_lvl = 1'b0;
        repeat ($urandom_range(0, cap)) begin
            held = ($urandom_range(0, 3) != 0);
            send_item(to_open & held, ~to_open & held, 1'b0, 1'b0);
        end
        open_lvl  = to_open;
        close_lvl = ~to_open;
        repeat ($urandom_range(1, 4)) send_item(1'b0, 1'b0, open_lvl, close_lvl);
    endtask

    // One random episode of shutter use; most are well-formed moves.
    task automatic shutter_episode(input int cap);
        int   kind;
        logic dir;
        kind    = $urandom_range(0, 9);
        dir     = 1'($urandom_range(0, 1));
        tx_calm = ($urandom_range(0, 4) == 0);
        // buttons released first so the next press is an edge
        repeat ($urandom_range(1, 3)) send_item(1'b0, 1'b0, open_lvl, close_lvl);
        case (kind)
            0, 1, 2: begin
                send_item(1'b1, 1'b0, open_lvl, close_lvl);
                travel(1'b1, cap);
            end
            3, 4, 5: begin
                send_item(1'b0, 1'b1, open_lvl, close_lvl);
                travel(1'b0, cap);
            end
            6: begin
                // reversal: the other button stops the move
                send_item(dir, ~dir, open_lvl, close_lvl);
                repeat ($urandom_range(0, 4)) send_item(dir, ~dir, 1'b0, 1'b0);
                send_item(1'b1, 1'b1, 1'b0, 1'b0);
                open_lvl  = 1'b0;
                close_lvl = 1'b0;
                repeat ($urandom_range(1, 3)) send_item(1'b0, 1'b0, 1'b0, 1'b0);
            end
            7: begin
                send_item(1'b1, 1'b1, open_lvl, close_lvl);
                travel(1'b0, cap);
            end
            8: begin
                // both end sensors at once while idle, then a press on top
                open_lvl  = 1'b1;
                close_lvl = 1'b1;
                repeat ($urandom_range(1, 3)) send_item(1'b0, 1'b0, 1'b1, 1'b1);
                send_item(dir, ~dir, 1'b1, 1'b1);
                repeat ($urandom_range(0, 3)) send_item(1'b0, 1'b0, 1'b1, 1'b1);
            end
            default: begin
                repeat ($urandom_range(2, 8)) begin
                    send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                open_lvl  = 1'($urandom_range(0, 1));
                close_lvl = 1'($urandom_range(0, 1));
            end
        endcase
    endtask

    // One register setting: quiet the block, write all four registers, then
    // random episodes. Motion lengths follow the timeouts so that moves both
    // finish in time and run out.
    task automatic run_phase(input logic [smc_pkg::CfgW-1:0] open_to,
                             input logic [smc_pkg::CfgW-1:0] close_to,
                             input logic [smc_pkg::CfgW-1:0] motion_bl,
                             input logic [smc_pkg::CfgW-1:0] error_bl,
                             input int n_items);
        int cap;
        int target;
        drain();
        write_regs(open_to, close_to, motion_bl, error_bl);
        cap    = (open_to > close_to) ? int'(open_to) : int'(close_to);
        cap    = (cap <= 40) ? cap + 3 : 60;
        target = items_sent + n_items;
        while (items_sent < target) shutter_episode(cap);
    endtask

    initial begin : stimulus
        aresetn        <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= smc_pkg::CFG_OPEN_TIMEOUT;
        cfg_wdata      <= '0;
        s_valid        <= 1'b0;
        s_open_button  <= 1'b0;
        s_close_button <= 1'b0;
        s_open_sensor  <= 1'b0;
        s_close_sensor <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: short timeouts and blinks so every path shows up quickly
        drain();
        write_regs(16'd3, 16'd4, 16'd2, 16'd1);
        tx_calm = 1'b1;
        foreach (DIRECTED_TICKS[i]) begin
            send_item(DIRECTED_TICKS[i][3], DIRECTED_TICKS[i][2],
                      DIRECTED_TICKS[i][1], DIRECTED_TICKS[i][0]);
        end
        open_lvl  = 1'b1;
        close_lvl = 1'b0;

        // random phases across the register range, extremes included
        run_phase(16'd1, 16'd1, 16'd1, 16'd1, 200);
        run_phase(16'd0, 16'd0, 16'd0, 16'd0, 200);
        run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 200);
        run_phase(smc_pkg::OpenTimeoutRst, smc_pkg::CloseTimeoutRst,
                  smc_pkg::MotionBlinkRst, smc_pkg::ErrorBlinkRst, 200);
        run_phase(16'($urandom_range(2, 30)), 16'($urandom_range(2, 30)),
                  16'($urandom_range(2, 30)), 16'($urandom_range(2, 30)), 200);
        run_phase(16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)),
                  16'($urandom_range(1, 12)), 16'($urandom_range(1, 12)), 200);
        run_phase(16'd7, 16'hFFFF, 16'd0, 16'd3, 200);
        run_phase(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                  16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)), 200);

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
